// ===== rtl/n2cw_pkg.sv =====
package n2cw_pkg;

    localparam int unsigned BIN_W   = 32;
    localparam int unsigned DIGITS  = 10;
    localparam int unsigned BCD_W   = DIGITS * 4;
    localparam int unsigned FRAC_W  = 7;
    localparam int unsigned TOK_W   = 4;
    localparam int unsigned CNT_W   = 5;

    localparam logic [FRAC_W-1:0] FRAC_MAX = 7'd99;

    // word tokens
    localparam logic [TOK_W-1:0] TOK_ZERO     = 4'd0;
    localparam logic [TOK_W-1:0] TOK_TEN      = 4'd10;
    localparam logic [TOK_W-1:0] TOK_HUNDRED  = 4'd11;
    localparam logic [TOK_W-1:0] TOK_THOUSAND = 4'd12;
    localparam logic [TOK_W-1:0] TOK_WAN      = 4'd13;
    localparam logic [TOK_W-1:0] TOK_YI       = 4'd14;
    localparam logic [TOK_W-1:0] TOK_POINT    = 4'd15;

    // digit positions, most significant decimal digit first
    localparam logic [3:0] POS_TOP = 4'd9;
    localparam logic [3:0] POS_YI  = 4'd8;
    localparam logic [3:0] POS_WAN = 4'd4;
    localparam logic [3:0] POS_LOW = 4'd0;

    // place within a group of four digits
    localparam logic [1:0] PLACE_UNIT     = 2'd0;
    localparam logic [1:0] PLACE_TEN      = 2'd1;
    localparam logic [1:0] PLACE_HUNDRED  = 2'd2;
    localparam logic [1:0] PLACE_THOUSAND = 2'd3;

    // bits of the per-digit word mask, in speaking order
    localparam int unsigned MB_ZERO  = 0;
    localparam int unsigned MB_DIGIT = 1;
    localparam int unsigned MB_PLACE = 2;
    localparam int unsigned MB_GROUP = 3;

    typedef enum logic [1:0] {
        SPK_NONE,
        SPK_ON,
        SPK_ZERO
    } spk_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CONV,
        ST_LOAD,
        ST_EMIT,
        ST_INTZ,
        ST_POINT,
        ST_TENTHS,
        ST_UNITS,
        ST_FLUSH
    } state_t;

endpackage

// ===== rtl/n2cw_bcd.sv =====
module n2cw_bcd
    import n2cw_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [BIN_W-1:0] bin_in,
    output logic             done,
    output logic [BCD_W-1:0] bcd_out
);

    logic [BIN_W-1:0] bin_reg;
    logic [BCD_W-1:0] bcd_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [BCD_W-1:0] adj;

    // add three to every digit of five or more before the shift
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            if (bcd_reg[i*4 +: 4] >= 4'd5) begin
                adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end else begin
                adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(BIN_W - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            bin_reg <= bin_in;
            bcd_reg <= '0;
        end else if (run_reg) begin
            bin_reg <= {bin_reg[BIN_W-2:0], 1'b0};
            bcd_reg <= {adj[BCD_W-2:0], bin_reg[BIN_W-1]};
        end
    end

    assign done    = done_reg;
    assign bcd_out = bcd_reg;

endmodule

// ===== rtl/number_to_chinese_word_tokens_core.sv =====
// Spoken Chinese reading of an amount, as a run of word tokens.
//
// Input channel (s_): one request carries a 32-bit unsigned integer part and a
// hundredths value; values of 100 and above read as 99. s_tready is high only
// while the block is idle, so one request is worked on at a time.
// Result channel (m_): one word token per transfer, 0-9 digits, 10 ten,
// 11 hundred, 12 thousand, 13 ten-thousand, 14 hundred-million, 15 point.
// m_tlast marks the final word of each reading.
//
// Operation: the integer part is converted to ten decimal digits one bit per
// cycle, then the digits are walked one per cycle, waiting while the output
// stages are full, with an extra step per integer word spoken, followed by
// the zero and fraction words and a step to release the final word. The next
// request is taken once the final word is released; the bit-serial
// conversion and the one-word-per-cycle walk set the request rate.
// A stalled receiver holds the current word in the output register and one
// more in a holding stage; the walk waits until either frees up.
// Reset returns the block to idle and drops any partly delivered reading.
module number_to_chinese_word_tokens_core
    import n2cw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] integer_part, [38:32] hundredths
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [3:0] word_token
    output logic        m_tlast    // last_token
);

    state_t state_reg, state_next;

    logic             conv_done;
    logic [BCD_W-1:0] conv_bcd;
    logic             s_accept;

    logic [BCD_W-1:0] walk_reg;
    logic [3:0]       pos_reg;
    logic [3:0]       dig_reg;
    logic [3:0]       mask_reg;
    spk_t             spk_reg;
    logic             grp_nz_reg;

    logic             frac_nz_reg;
    logic [3:0]       tenths_reg;
    logic [3:0]       units_reg;

    logic             pend_v_reg;
    logic [TOK_W-1:0] pend_tok_reg;
    logic             out_v_reg;
    logic [TOK_W-1:0] out_tok_reg;
    logic             out_last_reg;

    logic             out_free;
    logic             adv;
    logic             emit_valid;
    logic [TOK_W-1:0] emit_tok;
    logic             gen;

    logic [FRAC_W-1:0] frac_sat;
    logic [14:0]       frac_prod;
    logic [3:0]        frac_tenths;
    logic [FRAC_W-1:0] frac_units;

    logic [3:0]       cur_d;
    logic [1:0]       place;
    logic             d_nz;
    logic             grp_any;
    logic             grp_end;
    logic [3:0]       load_mask;
    spk_t             load_spk;
    logic [3:0]       mask_rest;
    logic [TOK_W-1:0] mask_tok;
    logic [TOK_W-1:0] place_tok;

    assign s_accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);

    n2cw_bcd u_bcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (s_accept),
        .bin_in  (s_tdata[BIN_W-1:0]),
        .done    (conv_done),
        .bcd_out (conv_bcd)
    );

    // split the fraction: tenths by multiply-and-shift, valid below 160
    always_comb begin
        if (s_tdata[38:32] > FRAC_MAX) begin
            frac_sat = FRAC_MAX;
        end else begin
            frac_sat = s_tdata[38:32];
        end
        frac_prod   = 15'(frac_sat) * 15'd205;
        frac_tenths = frac_prod[14:11];
        frac_units  = frac_sat - 7'(frac_tenths) * 7'd10;
    end

    // decide which words the current digit speaks
    always_comb begin
        cur_d   = walk_reg[BCD_W-1 -: 4];
        place   = pos_reg[1:0];
        d_nz    = (cur_d != 4'd0);
        grp_end = (place == PLACE_UNIT) && (pos_reg != POS_LOW);
        grp_any = grp_nz_reg || d_nz;

        load_mask[MB_ZERO]  = d_nz && (spk_reg == SPK_ZERO);
        load_mask[MB_DIGIT] = d_nz && !((place == PLACE_TEN) && (spk_reg == SPK_NONE)
                                        && (cur_d == 4'd1));
        load_mask[MB_PLACE] = d_nz && (place != PLACE_UNIT);
        load_mask[MB_GROUP] = grp_end && grp_any;

        if (grp_end && grp_any) begin
            load_spk = SPK_ON;
        end else if (d_nz) begin
            load_spk = SPK_ON;
        end else if (spk_reg != SPK_NONE) begin
            load_spk = SPK_ZERO;
        end else begin
            load_spk = spk_reg;
        end
    end

    always_comb begin
        unique case (pos_reg[1:0])
            PLACE_THOUSAND: place_tok = TOK_THOUSAND;
            PLACE_HUNDRED:  place_tok = TOK_HUNDRED;
            PLACE_TEN:      place_tok = TOK_TEN;
            PLACE_UNIT:     place_tok = TOK_ZERO;
        endcase

        mask_rest = mask_reg & (mask_reg - 4'd1);

        priority if (mask_reg[MB_ZERO]) begin
            mask_tok = TOK_ZERO;
        end else if (mask_reg[MB_DIGIT]) begin
            mask_tok = dig_reg;
        end else if (mask_reg[MB_PLACE]) begin
            mask_tok = place_tok;
        end else if (pos_reg == POS_YI) begin
            mask_tok = TOK_YI;
        end else begin
            mask_tok = TOK_WAN;
        end
    end

    assign out_free = !out_v_reg || m_tready;
    assign adv      = !pend_v_reg || out_free;

    // words offered by each state
    always_comb begin
        emit_valid = 1'b0;
        emit_tok   = TOK_ZERO;
        unique case (state_reg)
            ST_EMIT: begin
                emit_valid = 1'b1;
                emit_tok   = mask_tok;
            end
            ST_INTZ: begin
                emit_valid = (spk_reg == SPK_NONE);
                emit_tok   = TOK_ZERO;
            end
            ST_POINT: begin
                emit_valid = frac_nz_reg;
                emit_tok   = TOK_POINT;
            end
            ST_TENTHS: begin
                emit_valid = frac_nz_reg;
                emit_tok   = tenths_reg;
            end
            ST_UNITS: begin
                emit_valid = (units_reg != 4'd0);
                emit_tok   = units_reg;
            end
            default: ;
        endcase
    end

    assign gen = emit_valid && adv;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                if (conv_done) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (load_mask != 4'd0) begin
                    state_next = ST_EMIT;
                end else if (pos_reg == POS_LOW) begin
                    state_next = ST_INTZ;
                end
            end
            ST_EMIT: begin
                if (adv && (mask_rest == 4'd0)) begin
                    state_next = (pos_reg == POS_LOW) ? ST_INTZ : ST_LOAD;
                end
            end
            ST_INTZ: begin
                if (!emit_valid || adv) begin
                    state_next = ST_POINT;
                end
            end
            ST_POINT: begin
                if (!emit_valid || adv) begin
                    state_next = ST_TENTHS;
                end
            end
            ST_TENTHS: begin
                if (!emit_valid || adv) begin
                    state_next = ST_UNITS;
                end
            end
            ST_UNITS: begin
                if (!emit_valid || adv) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // digit walk
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spk_reg    <= SPK_NONE;
            grp_nz_reg <= 1'b0;
            pos_reg    <= POS_TOP;
            mask_reg   <= '0;
        end else begin
            unique case (state_reg)
                ST_CONV: begin
                    spk_reg    <= SPK_NONE;
                    grp_nz_reg <= 1'b0;
                    pos_reg    <= POS_TOP;
                    mask_reg   <= '0;
                end
                ST_LOAD: begin
                    mask_reg   <= load_mask;
                    spk_reg    <= load_spk;
                    grp_nz_reg <= (place == PLACE_UNIT) ? 1'b0 : grp_any;
                    if ((load_mask == 4'd0) && (pos_reg != POS_LOW)) begin
                        pos_reg <= pos_reg - 4'd1;
                    end
                end
                ST_EMIT: begin
                    if (adv) begin
                        mask_reg <= mask_rest;
                        if ((mask_rest == 4'd0) && (pos_reg != POS_LOW)) begin
                            pos_reg <= pos_reg - 4'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            frac_nz_reg <= (frac_sat != '0);
            tenths_reg  <= frac_tenths;
            units_reg   <= frac_units[3:0];
        end
        if (state_reg == ST_CONV && conv_done) begin
            walk_reg <= conv_bcd;
        end else if (state_reg == ST_LOAD) begin
            walk_reg <= {walk_reg[BCD_W-5:0], 4'd0};
            dig_reg  <= cur_d;
        end
    end

    // hold each new word one step so the final one can carry tlast
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end else begin
            if (gen) begin
                pend_v_reg <= 1'b1;
                if (pend_v_reg) begin
                    out_v_reg <= 1'b1;
                end else if (m_tready) begin
                    out_v_reg <= 1'b0;
                end
            end else if (state_reg == ST_FLUSH && out_free) begin
                pend_v_reg <= 1'b0;
                out_v_reg  <= 1'b1;
            end else if (m_tready) begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (gen) begin
            pend_tok_reg <= emit_tok;
            if (pend_v_reg) begin
                out_tok_reg  <= pend_tok_reg;
                out_last_reg <= 1'b0;
            end
        end else if (state_reg == ST_FLUSH && out_free) begin
            out_tok_reg  <= pend_tok_reg;
            out_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {4'd0, out_tok_reg};
    assign m_tlast  = out_last_reg;

    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !pend_v_reg)
        else $error("word left in holding stage while idle");

    a_flush_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FLUSH) |-> pend_v_reg)
        else $error("reading finished without a final word");

    a_emit_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (mask_reg != 4'd0))
        else $error("emit state with no word to speak");

    a_conv_in_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        conv_done |-> (state_reg == ST_CONV))
        else $error("conversion finished outside conversion state");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (pos_reg <= POS_TOP))
        else $error("digit position out of range");

endmodule

// ===== tb/sv/n2cw_reading_checker.sv =====
module n2cw_reading_checker
    import n2cw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] integer_part, [38:32] hundredths
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [3:0] word_token
    input  logic        m_tlast,   // last_token
    input  logic        run_over,
    output int          mismatch_count,
    output int          words_pending,
    output int          words_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_WORDS = 23;

    typedef struct packed {
        logic [TOK_W-1:0] token;
        logic             last;
    } spoken_word_t;

    spoken_word_t     expected_words[$];
    logic [TOK_W-1:0] reading[$];
    spoken_word_t     want;
    int               faults = 0;
    int               checked = 0;
    logic             leftover_done = 1'b0;

    // Read one group of four digits, 1..9999, thousands first.
    function automatic void say_group(input int unsigned grp, inout spk_t mode);
        int unsigned      place_div [4] = '{1, 10, 100, 1000};
        logic [TOK_W-1:0] place_word [4] = '{TOK_ZERO, TOK_TEN, TOK_HUNDRED, TOK_THOUSAND};
        int unsigned      d;
        for (int place = PLACE_THOUSAND; place >= int'(PLACE_UNIT); place--) begin
            d = (grp / place_div[place]) % 10;
            if (d != 0) begin
                if (mode == SPK_ZERO)
                    reading.push_back(TOK_ZERO);
                // drop the leading one of a bare ten
                if (place != PLACE_TEN || mode != SPK_NONE || d != 1)
                    reading.push_back(TOK_W'(d));
                if (place != PLACE_UNIT)
                    reading.push_back(place_word[place]);
                mode = SPK_ON;
            end else if (mode != SPK_NONE) begin
                mode = SPK_ZERO;
            end
        end
    endfunction

    function automatic void predict_reading(input logic [31:0] amount,
                                            input logic [FRAC_W-1:0] hund);
        int unsigned rest;
        int unsigned grp;
        int unsigned frac;
        int          n;
        spk_t        mode;
        reading.delete();
        mode = SPK_NONE;
        frac = (hund > FRAC_MAX) ? FRAC_MAX : hund;
        if (amount != 0) begin
            rest = amount;
            grp  = rest / 32'd100_000_000;
            rest = rest % 32'd100_000_000;
            if (grp != 0) begin
                say_group(grp, mode);
                reading.push_back(TOK_YI);
                mode = SPK_ON;
            end
            grp  = rest / 10000;
            rest = rest % 10000;
            if (grp != 0) begin
                say_group(grp, mode);
                reading.push_back(TOK_WAN);
                mode = SPK_ON;
            end else if (mode != SPK_NONE) begin
                mode = SPK_ZERO;
            end
            if (rest != 0)
                say_group(rest, mode);
        end else begin
            reading.push_back(TOK_ZERO);
        end
        if (frac != 0) begin
            reading.push_back(TOK_POINT);
            reading.push_back(TOK_W'(frac / 10));
            if (frac % 10 != 0)
                reading.push_back(TOK_W'(frac % 10));
        end
        n = (reading.size() > MAX_WORDS) ? MAX_WORDS : reading.size();
        for (int i = 0; i < n; i++)
            expected_words.push_back('{token: reading[i], last: (i == n - 1)});
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                checked++;
                if (expected_words.size() == 0) begin
                    $error("word_token %0d (last %0b) arrived with no reading pending",
                           m_tdata[TOK_W-1:0], m_tlast);
                    faults++;
                end else begin
                    want = expected_words.pop_front();
                    if (m_tdata[TOK_W-1:0] !== want.token) begin
                        $error("word_token: expected %0d, got %0d",
                               want.token, m_tdata[TOK_W-1:0]);
                        faults++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last_token: expected %0b, got %0b", want.last, m_tlast);
                        faults++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_reading(s_tdata[31:0], s_tdata[38:32]);
            if (run_over && !leftover_done) begin
                leftover_done = 1'b1;
                if (expected_words.size() != 0) begin
                    $error("%0d word tokens still expected at the end", expected_words.size());
                    faults += expected_words.size();
                end
            end
        end
        mismatch_count <= faults;
        words_pending  <= expected_words.size();
        words_checked  <= checked;
    end

endmodule

// ===== tb/sv/tb_number_to_chinese_word_tokens_core.sv =====
module tb_number_to_chinese_word_tokens_core
    import n2cw_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_DIRECTED  = 24;
    localparam int N_RANDOM    = 126;
    localparam int LONG_HOLD   = 300;
    localparam int CYCLE_LIMIT = 400_000;

    typedef enum {RX_STEADY, RX_HALF, RX_SPARSE, RX_MASKED} rx_style_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        run_over = 1'b0;

    int mismatch_count;
    int words_pending;
    int words_checked;

    int        items_sent = 0;
    int        burst_left = 0;
    int        hold_req = 0;
    int        hold_seen = 0;
    int        holds_asked = 0;
    int        hold_left = 0;
    int        seg_left = 0;
    rx_style_t rx_style = RX_STEADY;
    logic [7:0] rx_mask = 8'h01;
    int        cycle_count = 0;

    logic [31:0] directed_amounts [N_DIRECTED] = '{
        32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd7, 32'd10, 32'd11,
        32'd19, 32'd110, 32'd1010, 32'd100000, 32'd100010, 32'd1000001,
        32'd100000000, 32'd100000001, 32'd1000000010, 32'd20304050,
        32'd1234567890, 32'd2147483648, 32'd4294967295, 32'd4294967295,
        32'd1000010000, 32'd10000
    };
    logic [FRAC_W-1:0] directed_hundredths [N_DIRECTED] = '{
        7'd0, 7'd5, 7'd50, 7'd99, 7'd127, 7'd100, 7'd0, 7'd1,
        7'd70, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
        7'd0, 7'd0, 7'd0, 7'd0,
        7'd12, 7'd64, 7'd99, 7'd0,
        7'd0, 7'd9
    };

    number_to_chinese_word_tokens_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    n2cw_reading_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .run_over       (run_over),
        .mismatch_count (mismatch_count),
        .words_pending  (words_pending),
        .words_checked  (words_checked)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timed out after %0d cycles", CYCLE_LIMIT);
            $display("number_to_chinese_word_tokens_core regression: fail");
            $finish;
        end
    end

    // Receiver: random stall styles in segments, plus a long hold-off on request.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= LONG_HOLD;
            m_tready  <= 1'b0;
        end else begin
            if (seg_left == 0) begin
                seg_left <= $urandom_range(4, 60);
                rx_style <= rx_style_t'($urandom_range(0, 3));
                rx_mask  <= 8'($urandom_range(1, 255));
            end else begin
                seg_left <= seg_left - 1;
                rx_mask  <= {rx_mask[6:0], rx_mask[7]};
            end
            case (rx_style)
                RX_STEADY: m_tready <= 1'b1;
                RX_HALF:   m_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                default:   m_tready <= rx_mask[0];
            endcase
        end
    end

    function automatic logic [31:0] pick_amount();
        logic [63:0] v;
        int unsigned ndig;
        v = 0;
        case ($urandom_range(0, 7))
            0, 1: v = $urandom();
            2:    v = $urandom_range(0, 99);
            3:    v = $urandom_range(0, 99999);
            4, 5: begin
                // decimal digits with many zeros, to exercise the zero word
                ndig = $urandom_range(1, 10);
                repeat (ndig)
                    v = v * 10 + (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 9));
                if (v > 64'hFFFF_FFFF)
                    v = v % 64'd1_000_000_000;
            end
            6: begin
                v = 64'($urandom_range(0, 41)) * 64'd100_000_000
                    + (($urandom_range(0, 1) == 1) ? 64'($urandom_range(0, 9999)) * 64'd10000 : 0)
                    + 64'($urandom_range(0, 20));
            end
            default: begin
                v = 64'($urandom_range(1, 4));
                repeat ($urandom_range(0, 9))
                    v = v * 10;
            end
        endcase
        return v[31:0];
    endfunction

    function automatic logic [FRAC_W-1:0] pick_hundredths();
        case ($urandom_range(0, 5))
            0, 1:    return '0;
            2:       return FRAC_W'($urandom_range(1, 99));
            3:       return FRAC_W'($urandom_range(1, 9) * 10);
            4:       return FRAC_W'($urandom_range(100, 127));
            default: return FRAC_W'($urandom_range(0, 127));
        endcase
    endfunction

    task automatic send_request(input logic [31:0] amount, input logic [FRAC_W-1:0] hund);
        int gap;
        s_tdata  <= {1'b0, hund, amount};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (words_pending != 0);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_request(directed_amounts[i], directed_hundredths[i]);
        wait_drained();

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == 40 || i == 110) begin
                // stall the receiver for a long stretch while requests keep coming
                hold_req <= hold_req + 1;
                holds_asked++;
            end
            if (i == 80)
                wait_drained();
            send_request(pick_amount(), pick_hundredths());
        end

        wait_drained();
        repeat (100) @(posedge aclk);
        run_over <= 1'b1;
        repeat (2) @(posedge aclk);

        $display("read %0d amounts (%0d directed, zero, tens, sparse zeros, full range)",
                 items_sent, N_DIRECTED);
        $display("checked %0d word tokens across %0d long receiver hold-offs",
                 words_checked, holds_asked);
        if (mismatch_count == 0) begin
            $display("number_to_chinese_word_tokens_core regression: pass");
        end else begin
            $display("number_to_chinese_word_tokens_core regression: fail");
        end
        $finish;
    end

endmodule
